FILE: src/hsfd_pkg.sv
// Package for the humidity sensor frame decoder: byte position codes, the
// frame record passed to the scaler, CRC-8 and divide-by-65535 helpers.
// No dependencies.
package hsfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned TCENTI_W = 15;
    localparam int unsigned HCENTI_W = 14;
    localparam int unsigned OUT_W    = 64;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;  // x^8+x^5+x^4+1, top bit implied
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [14:0] T_SCALE  = 15'd17500;
    localparam logic [13:0] H_SCALE  = 14'd10000;
    localparam logic [15:0] T_OFFSET = 16'd4500;

    // index of the next frame byte
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_pos;

    typedef struct packed {
        logic [WORD_W-1:0] raw_temperature;
        logic [WORD_W-1:0] raw_humidity;
        logic              temperature_crc_ok;
        logic              humidity_crc_ok;
    } t_frame;

    typedef struct packed {
        logic [TCENTI_W-1:0] temperature_centi;
        logic [HCENTI_W-1:0] humidity_centi;
    } t_scaled;

    // one byte through CRC-8, MSB first
    function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 2^31: q0 = x >> 16, remainder x[15:0] + q0,
    // one correction when that remainder reaches 65535
    function automatic logic [WORD_W-1:0] div_65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[30:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        if (rem >= 17'd65535) begin
            return {1'b0, q0} + 16'd1;
        end else begin
            return {1'b0, q0};
        end
    endfunction

endpackage

FILE: src/hsfd_frame.sv
// Frame assembler: byte position, running CRC-8 and the held words.
// Flags the sixth byte and presents the complete frame. Uses hsfd_pkg.
module hsfd_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_start,
    output logic                  o_done,
    output hsfd_pkg::t_frame      o_frame
);

    hsfd_pkg::t_pos  r_pos, n_pos, w_pos;
    logic [7:0]      r_crc, n_crc;
    logic [7:0]      r_high, n_high;
    logic [15:0]     r_temp_word, n_temp_word;
    logic            r_temp_ok, n_temp_ok;
    logic [15:0]     r_hum_word, n_hum_word;

    // start flag overrides the stored position
    assign w_pos = i_start ? hsfd_pkg::POS_T_HI : r_pos;

    // next position
    always_comb begin
        case (w_pos)
            hsfd_pkg::POS_T_HI:  n_pos = hsfd_pkg::POS_T_LO;
            hsfd_pkg::POS_T_LO:  n_pos = hsfd_pkg::POS_T_CRC;
            hsfd_pkg::POS_T_CRC: n_pos = hsfd_pkg::POS_H_HI;
            hsfd_pkg::POS_H_HI:  n_pos = hsfd_pkg::POS_H_LO;
            hsfd_pkg::POS_H_LO:  n_pos = hsfd_pkg::POS_H_CRC;
            hsfd_pkg::POS_H_CRC: n_pos = hsfd_pkg::POS_T_HI;
            default:             n_pos = hsfd_pkg::POS_T_LO;  // treated as first byte
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_crc       = r_crc;
        n_high      = r_high;
        n_temp_word = r_temp_word;
        n_temp_ok   = r_temp_ok;
        n_hum_word  = r_hum_word;
        o_done      = 1'b0;
        case (w_pos)
            hsfd_pkg::POS_T_LO: begin
                n_crc       = hsfd_pkg::crc_feed(r_crc, i_byte);
                n_temp_word = {r_high, i_byte};
            end
            hsfd_pkg::POS_T_CRC: begin
                n_temp_ok = (r_crc == i_byte);
                n_crc     = hsfd_pkg::CRC_INIT;
            end
            hsfd_pkg::POS_H_LO: begin
                n_crc      = hsfd_pkg::crc_feed(r_crc, i_byte);
                n_hum_word = {r_high, i_byte};
            end
            hsfd_pkg::POS_H_CRC: begin
                n_crc  = hsfd_pkg::CRC_INIT;
                o_done = i_accept;
            end
            default: begin  // high byte of either word
                n_crc  = hsfd_pkg::crc_feed(hsfd_pkg::CRC_INIT, i_byte);
                n_high = i_byte;
            end
        endcase
        o_frame.raw_temperature    = r_temp_word;
        o_frame.raw_humidity       = r_hum_word;
        o_frame.temperature_crc_ok = r_temp_ok;
        o_frame.humidity_crc_ok    = (r_crc == i_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= hsfd_pkg::POS_T_HI;
            r_crc <= hsfd_pkg::CRC_INIT;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_high      <= n_high;
            r_temp_word <= n_temp_word;
            r_temp_ok   <= n_temp_ok;
            r_hum_word  <= n_hum_word;
        end
    end

endmodule

FILE: src/hsfd_scale.sv
// Scaler: raw words to hundredths of a degree C and of a percent,
// one constant multiply and a divide-by-65535 correction each. Uses hsfd_pkg.
module hsfd_scale (
    input  hsfd_pkg::t_frame   i_frame,
    output hsfd_pkg::t_scaled  o_scaled
);

    logic [30:0] w_t_prod;
    logic [29:0] w_h_prod;
    logic [15:0] w_t_q;
    logic [15:0] w_h_q;
    logic [15:0] w_t_diff;

    assign w_t_prod = 31'(i_frame.raw_temperature) * 31'(hsfd_pkg::T_SCALE);
    assign w_h_prod = 30'(i_frame.raw_humidity) * 30'(hsfd_pkg::H_SCALE);

    assign w_t_q = hsfd_pkg::div_65535(w_t_prod);
    assign w_h_q = hsfd_pkg::div_65535({1'b0, w_h_prod});

    // two's complement result, -4500..13000
    assign w_t_diff = w_t_q - hsfd_pkg::T_OFFSET;

    assign o_scaled.temperature_centi = w_t_diff[14:0];
    assign o_scaled.humidity_centi    = w_h_q[13:0];

endmodule

FILE: src/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder: frame assembler, scaler
// and the output register. Uses hsfd_pkg, hsfd_frame and hsfd_scale.
//
//  channel | dir | tdata                     | tuser           | notes
//  s_axis  | in  | [7:0] data_byte           | [0] frame_start | one frame byte
//  m_axis  | out | see m_axis_tdata below    | -               | one per six bytes
//
// One byte is taken per cycle, back to back. CRC and scaling are combinational
// between the frame registers and the output register, so the result is
// registered at the edge that takes the sixth byte and offered the next cycle.
// Reset sets the byte position to the first byte and the CRC to 0xFF.
// A held result stalls the input only while the output is not taken.
module humidity_sensor_frame_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
    input  logic                       s_axis_tuser,   // [0] frame_start
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [hsfd_pkg::OUT_W-1:0] m_axis_tdata    // [15:0] raw_temperature,
                                                       // [31:16] raw_humidity,
                                                       // [46:32] temperature_centi,
                                                       // [60:47] humidity_centi,
                                                       // [61] temperature_crc_ok,
                                                       // [62] humidity_crc_ok,
                                                       // [63] zero
);

    logic                       w_accept;
    logic                       w_done;
    hsfd_pkg::t_frame           w_frame;
    hsfd_pkg::t_scaled          w_scaled;
    logic                       r_out_valid;
    logic [hsfd_pkg::OUT_W-1:0] r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    hsfd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser),
        .o_done   (w_done),
        .o_frame  (w_frame)
    );

    hsfd_scale u_scale (
        .i_frame  (w_frame),
        .o_scaled (w_scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= {1'b0,
                           w_frame.humidity_crc_ok,
                           w_frame.temperature_crc_ok,
                           w_scaled.humidity_centi,
                           w_scaled.temperature_centi,
                           w_frame.raw_humidity,
                           w_frame.raw_temperature};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
